>>> rtl/lfu_cache_store_core_defines.svh
// Assertion macros for the LFU cache store; they expect clk and rst_n in scope.
`ifndef LFU_CACHE_STORE_CORE_DEFINES_SVH
`define LFU_CACHE_STORE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define LCS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu_cache_store_core: check failed");
`define LCS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu_cache_store_core: check failed");
`else
`define LCS_ASSERT_IMPL(lbl, ante, cons)
`define LCS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/lcs_pkg.sv
// Shared types and constants of the LFU cache store.
package lcs_pkg;
  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF   = 32;
  localparam int unsigned COUNT_BITS_DEF = 16;
  localparam logic [4:0]  CAP_RESET      = 5'd16;
  localparam logic        MODE_GET       = 1'b0;
  localparam logic        MODE_PUT       = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] lookup_key;
    logic [31:0] write_value;
  } lcs_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lcs_out_t;

  // update command broadcast to the row, applied by the addressed cell
  typedef struct packed {
    logic touch;
    logic load;
    logic set_data;
  } lcs_cmd_t;

  // found flags travelling down the chain
  typedef struct packed {
    logic hit;
    logic free;
    logic best;
  } lcs_flags_t;
endpackage

>>> rtl/lcs_cell.sv
// One entry of the store plus its stage of the search chain.
module lcs_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned IDX_W      = 4,
  parameter int unsigned USED_W     = 5,
  parameter int unsigned CELL_IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [KEY_BITS-1:0]   key_i,
  input  logic [31:0]           data_i,
  input  logic [31:0]           stamp_i,
  input  lcs_pkg::lcs_cmd_t     cmd_i,
  input  logic [IDX_W-1:0]      cmd_idx_i,
  input  lcs_pkg::lcs_flags_t   flg_i,
  input  logic [IDX_W-1:0]      hit_idx_i,
  input  logic [IDX_W-1:0]      free_idx_i,
  input  logic [IDX_W-1:0]      best_idx_i,
  input  logic [COUNT_BITS-1:0] best_cnt_i,
  input  logic [31:0]           best_age_i,
  input  logic [USED_W-1:0]     used_i,
  output lcs_pkg::lcs_flags_t   flg_o,
  output logic [IDX_W-1:0]      hit_idx_o,
  output logic [IDX_W-1:0]      free_idx_o,
  output logic [IDX_W-1:0]      best_idx_o,
  output logic [COUNT_BITS-1:0] best_cnt_o,
  output logic [31:0]           best_age_o,
  output logic [USED_W-1:0]     used_o,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [31:0]           data_o
);
  import lcs_pkg::*;

  localparam logic [IDX_W-1:0]      MY_IDX    = IDX_W'(CELL_IDX);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic                  valid_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [31:0]           data_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [31:0]           stamp_r;

  lcs_flags_t            flg_r, flg_nxt;
  logic [IDX_W-1:0]      hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [COUNT_BITS-1:0] best_cnt_r, best_cnt_nxt;
  logic [31:0]           best_age_r, best_age_nxt;
  logic [USED_W-1:0]     used_r;

  logic        sel;
  logic        match;
  logic        better;
  logic [31:0] age;

  assign sel   = (cmd_idx_i == MY_IDX);
  assign match = valid_r && (key_r == key_i);
  assign age   = stamp_i - stamp_r;
  // strict compare keeps the lower index on a full tie
  assign better = valid_r && (!flg_i.best || (count_r < best_cnt_i) ||
                  ((count_r == best_cnt_i) && (age > best_age_i)));

  always_comb begin
    flg_nxt      = flg_i;
    hit_idx_nxt  = hit_idx_i;
    free_idx_nxt = free_idx_i;
    best_idx_nxt = best_idx_i;
    best_cnt_nxt = best_cnt_i;
    best_age_nxt = best_age_i;
    if (!flg_i.hit && match) begin
      flg_nxt.hit = 1'b1;
      hit_idx_nxt = MY_IDX;
    end
    if (!flg_i.free && !valid_r) begin
      flg_nxt.free = 1'b1;
      free_idx_nxt = MY_IDX;
    end
    if (better) begin
      flg_nxt.best = 1'b1;
      best_idx_nxt = MY_IDX;
      best_cnt_nxt = count_r;
      best_age_nxt = age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flg_r   <= '0;
    end else begin
      flg_r <= flg_nxt;
      if (sel && cmd_i.load) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r  <= hit_idx_nxt;
    free_idx_r <= free_idx_nxt;
    best_idx_r <= best_idx_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_age_r <= best_age_nxt;
    used_r     <= used_i + USED_W'(valid_r);
    if (sel && cmd_i.load) begin
      key_r   <= key_i;
      data_r  <= data_i;
      count_r <= COUNT_BITS'(1);
      stamp_r <= stamp_i;
    end else if (sel && cmd_i.touch) begin
      if (count_r != COUNT_MAX) begin
        count_r <= count_r + COUNT_BITS'(1);
      end
      stamp_r <= stamp_i;
      if (cmd_i.set_data) begin
        data_r <= data_i;
      end
    end
  end

  assign flg_o      = flg_r;
  assign hit_idx_o  = hit_idx_r;
  assign free_idx_o = free_idx_r;
  assign best_idx_o = best_idx_r;
  assign best_cnt_o = best_cnt_r;
  assign best_age_o = best_age_r;
  assign used_o     = used_r;
  assign key_o      = key_r;
  assign data_o     = data_r;
endmodule

>>> rtl/lfu_cache_store_core.sv
// Top level of the LFU cache store: command control over a row of entry cells.
//
//  channel | handshake        | payload
//  input   | start / busy     | in_data  (mode, lookup_key, write_value)
//  result  | out_valid strobe | out_data (hit, read_value, evicted, evicted_key)
//  config  | cfg_we           | cfg_wdata (capacity_in_use)
//
// Each beat is latched, then the search ripples through the cell chain
// during the scan state, and then the update is applied.
// busy is high from the accepting edge until the result strobe.
// Synchronous active-low reset clears all valid bits at once.
// The result is shown for one cycle; the receiver cannot stall it.
`include "lfu_cache_store_core_defines.svh"
module lfu_cache_store_core #(
  parameter int unsigned ENTRIES    = lcs_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS   = lcs_pkg::KEY_BITS_DEF,
  parameter int unsigned COUNT_BITS = lcs_pkg::COUNT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  lcs_pkg::lcs_in_t  in_data,
  output logic             out_valid,
  output lcs_pkg::lcs_out_t out_data,
  input  logic             cfg_we,
  input  logic [4:0]       cfg_wdata
);
  import lcs_pkg::*;

  localparam int unsigned IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned USED_W = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY} state_t;

  state_t      state_r;
  logic [IDX_W-1:0] scan_r;
  lcs_in_t     req_r;
  logic [4:0]  cap_r;
  logic [31:0] stamp_r;
  logic        out_valid_r;
  lcs_out_t    out_r, out_nxt;

  lcs_cmd_t         cmd;
  logic [IDX_W-1:0] cmd_idx;
  logic             stamp_inc;
  logic [31:0]      cap_eff;
  logic             full;
  logic [KEY_BITS-1:0] req_key;

  lcs_flags_t            flg_c      [ENTRIES+1];
  logic [IDX_W-1:0]      hit_idx_c  [ENTRIES+1];
  logic [IDX_W-1:0]      free_idx_c [ENTRIES+1];
  logic [IDX_W-1:0]      best_idx_c [ENTRIES+1];
  logic [COUNT_BITS-1:0] best_cnt_c [ENTRIES+1];
  logic [31:0]           best_age_c [ENTRIES+1];
  logic [USED_W-1:0]     used_c     [ENTRIES+1];
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [31:0]           cell_data  [ENTRIES];

  assign req_key       = KEY_BITS'(req_r.lookup_key);
  assign flg_c[0]      = '0;
  assign hit_idx_c[0]  = '0;
  assign free_idx_c[0] = '0;
  assign best_idx_c[0] = '0;
  assign best_cnt_c[0] = '0;
  assign best_age_c[0] = '0;
  assign used_c[0]     = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lcs_cell #(
      .KEY_BITS  (KEY_BITS),
      .COUNT_BITS(COUNT_BITS),
      .IDX_W     (IDX_W),
      .USED_W    (USED_W),
      .CELL_IDX  (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .key_i     (req_key),
      .data_i    (req_r.write_value),
      .stamp_i   (stamp_r),
      .cmd_i     (cmd),
      .cmd_idx_i (cmd_idx),
      .flg_i     (flg_c[g]),
      .hit_idx_i (hit_idx_c[g]),
      .free_idx_i(free_idx_c[g]),
      .best_idx_i(best_idx_c[g]),
      .best_cnt_i(best_cnt_c[g]),
      .best_age_i(best_age_c[g]),
      .used_i    (used_c[g]),
      .flg_o     (flg_c[g+1]),
      .hit_idx_o (hit_idx_c[g+1]),
      .free_idx_o(free_idx_c[g+1]),
      .best_idx_o(best_idx_c[g+1]),
      .best_cnt_o(best_cnt_c[g+1]),
      .best_age_o(best_age_c[g+1]),
      .used_o    (used_c[g+1]),
      .key_o     (cell_key[g]),
      .data_o    (cell_data[g])
    );
  end

  assign cap_eff = (32'(cap_r) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(cap_r);
  assign full    = (32'(used_c[ENTRIES]) >= cap_eff);

  always_comb begin
    cmd       = '0;
    cmd_idx   = hit_idx_c[ENTRIES];
    stamp_inc = 1'b0;
    out_nxt   = '0;
    out_nxt.hit = flg_c[ENTRIES].hit;
    if (state_r == ST_APPLY) begin
      if (req_r.mode == MODE_GET) begin
        if (flg_c[ENTRIES].hit) begin
          cmd.touch          = 1'b1;
          stamp_inc          = 1'b1;
          out_nxt.read_value = cell_data[hit_idx_c[ENTRIES]];
        end
      end else if (cap_eff != 32'd0) begin
        if (flg_c[ENTRIES].hit) begin
          cmd.touch    = 1'b1;
          cmd.set_data = 1'b1;
          stamp_inc    = 1'b1;
        end else if (full && flg_c[ENTRIES].best) begin
          // victim slot is reused for the new key
          cmd.load            = 1'b1;
          cmd_idx             = best_idx_c[ENTRIES];
          stamp_inc           = 1'b1;
          out_nxt.evicted     = 1'b1;
          out_nxt.evicted_key = 32'(cell_key[best_idx_c[ENTRIES]]);
        end else if (flg_c[ENTRIES].free) begin
          cmd.load  = 1'b1;
          cmd_idx   = free_idx_c[ENTRIES];
          stamp_inc = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_r      <= '0;
      cap_r       <= CAP_RESET;
      stamp_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (stamp_inc) begin
        stamp_r <= stamp_r + 32'd1;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            state_r <= ST_SCAN;
            scan_r  <= '0;
          end
        end
        ST_SCAN: begin
          if (scan_r == IDX_W'(ENTRIES - 1)) begin
            state_r <= ST_APPLY;
          end else begin
            scan_r <= scan_r + IDX_W'(1);
          end
        end
        ST_APPLY: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      req_r <= in_data;
    end
    if (state_r == ST_APPLY) begin
      out_r <= out_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LCS_ASSERT_IMPL(a_strobe_after_apply, out_valid_r, $past(state_r == ST_APPLY))
  `LCS_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `LCS_ASSERT_IMPL(a_stamp_only_apply, $past(rst_n) && !$stable(stamp_r),
                   $past(state_r == ST_APPLY))
endmodule

>>> sim/lfu_cache_store_core_test.sv
// Self-checking testbench for the LFU cache store: command-style stimulus with a scoreboard.
`timescale 1ns / 1ps
module lfu_cache_store_core_test;
  import lcs_pkg::*;

  localparam int NUM_SLOTS = 16;
  localparam int RAND_ITEMS = 450;

  // Behavioral copy of the store; predicts one result per command.
  class lfu_scoreboard;
    bit          slot_valid [NUM_SLOTS];
    bit [31:0]   slot_key   [NUM_SLOTS];
    bit [31:0]   slot_data  [NUM_SLOTS];
    bit [15:0]   slot_count [NUM_SLOTS];
    bit [31:0]   slot_stamp [NUM_SLOTS];
    bit [31:0]   stamp_now;
    bit [4:0]    capacity;
    lcs_out_t    pending [$];
    int          mismatches;

    function void clear_store();
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
      stamp_now = '0;
      capacity = CAP_RESET;
    endfunction

    function void bump(int i);
      if (slot_count[i] != 16'hffff) slot_count[i]++;
      slot_stamp[i] = stamp_now;
      stamp_now++;
    endfunction

    function int find_slot(bit [31:0] k);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (slot_valid[i] && slot_key[i] == k) return i;
      return -1;
    endfunction

    function int pick_victim();
      int best;
      bit [31:0] best_age, age;
      best = -1;
      best_age = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_valid[i]) continue;
        age = stamp_now - slot_stamp[i];
        if (best < 0 || slot_count[i] < slot_count[best] ||
            (slot_count[i] == slot_count[best] && age > best_age)) begin
          best = i;
          best_age = age;
        end
      end
      return best;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      foreach (slot_valid[i]) n += slot_valid[i];
      return n;
    endfunction

    function void note_command(lcs_in_t cmd);
      lcs_out_t r;
      int slot, target, cap;
      r = '0;
      cap = (capacity > NUM_SLOTS) ? NUM_SLOTS : capacity;
      slot = find_slot(cmd.lookup_key);
      target = -1;
      r.hit = (slot >= 0);
      if (cmd.mode == MODE_GET) begin
        if (slot >= 0) begin
          bump(slot);
          r.read_value = slot_data[slot];
        end
      end else if (cap != 0) begin
        if (slot >= 0) begin
          bump(slot);
          slot_data[slot] = cmd.write_value;
        end else begin
          if (occupancy() >= cap) begin
            target = pick_victim();
            if (target >= 0) begin
              slot_valid[target] = 1'b0;
              r.evicted = 1'b1;
              r.evicted_key = slot_key[target];
            end
          end
          if (target < 0)
            for (int i = 0; i < NUM_SLOTS; i++)
              if (!slot_valid[i]) begin
                target = i;
                break;
              end
          if (target >= 0) begin
            slot_valid[target] = 1'b1;
            slot_key[target] = cmd.lookup_key;
            slot_data[target] = cmd.write_value;
            slot_count[target] = 16'd1;
            slot_stamp[target] = stamp_now;
            stamp_now++;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(lcs_out_t got);
      lcs_out_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit || got.read_value !== exp.read_value ||
          got.evicted !== exp.evicted || got.evicted_key !== exp.evicted_key) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p got %p", exp, got);
      end
    endfunction
  endclass

  logic clk, rst_n, start, busy, out_valid, cfg_we;
  logic [4:0] cfg_wdata;
  lcs_in_t in_data;
  lcs_out_t out_data;
  lfu_scoreboard sb;
  bit [31:0] key_pool [8];

  lfu_cache_store_core uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  always @(posedge clk)
    if (rst_n && out_valid) sb.check_result(out_data);

  // Hold start until busy is low at an edge, then the beat is taken.
  // start drops after each beat; busy is high during that gap anyway.
  task automatic send_cmd(bit mode, bit [31:0] key, bit [31:0] val);
    lcs_in_t c;
    c.mode = mode;
    c.lookup_key = key;
    c.write_value = val;
    start <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic write_capacity(bit [4:0] cap);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    sb.capacity = cap;
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n);
    int burst;
    bit [31:0] k;
    while (n > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && n > 0) begin
        // mostly keys from a small pool so hits and evictions happen
        k = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)] + $urandom_range(0, 15)
                                       : $urandom;
        send_cmd(1'($urandom_range(0, 1)), k, $urandom);
        burst--;
        n--;
      end
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  endtask

  initial begin
    sb = new();
    sb.clear_store();
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hffff_fff0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extreme keys/values, hit, update, miss, ties, eviction
    send_cmd(MODE_GET, 32'h0, 32'h0);
    send_cmd(MODE_PUT, 32'h0, 32'hffff_ffff);
    send_cmd(MODE_PUT, 32'hffff_ffff, 32'h0);
    send_cmd(MODE_GET, 32'h0, 32'h1234_5678);
    send_cmd(MODE_PUT, 32'hffff_ffff, 32'ha5a5_5a5a);
    send_cmd(MODE_GET, 32'hffff_ffff, 32'h0);
    write_capacity(5'd2);
    send_cmd(MODE_PUT, 32'h5555_5555, 32'h1);   // evicts
    send_cmd(MODE_PUT, 32'haaaa_aaaa, 32'h2);   // lower count loses: the key just loaded goes
    send_cmd(MODE_GET, 32'h5555_5555, 32'h0);
    write_capacity(5'd0);
    send_cmd(MODE_PUT, 32'h1, 32'h3);           // no-op on zero capacity
    send_cmd(MODE_GET, 32'haaaa_aaaa, 32'h0);
    write_capacity(5'd1);                       // below occupancy
    send_cmd(MODE_PUT, 32'h2, 32'h4);
    send_cmd(MODE_PUT, 32'h3, 32'h5);
    write_capacity(5'd31);                      // acts as full size

    random_phase(RAND_ITEMS / 5);
    drain();                                    // sender waits for all results
    write_capacity(5'd3);
    random_phase(RAND_ITEMS / 5);
    write_capacity(5'd16);
    random_phase(RAND_ITEMS / 5);
    write_capacity(5'd0);
    random_phase(RAND_ITEMS / 10);
    write_capacity(5'd8);
    random_phase(RAND_ITEMS / 5);
    write_capacity(5'd15);
    random_phase(RAND_ITEMS / 10);
    drain();

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> lfu_cache_store_core.f
+incdir+rtl
rtl/lcs_pkg.sv
rtl/lcs_cell.sv
rtl/lfu_cache_store_core.sv
sim/lfu_cache_store_core_test.sv
